// ===== rtl/tld_pkg.sv =====
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types and constants for the terminal input line discipline.
// ----------------------------------------------------------------------------
package tld_pkg;

    localparam int QUEUE_DEPTH_DEF = 1024;

    // status field width (lines_ready, fill_level)
    localparam int STAT_W = 10;
    localparam logic [STAT_W-1:0] LINE_MAX = 10'd1023;

    // configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    // character codes
    localparam logic [7:0] CH_NL       = 8'd10;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_DEL      = 8'd127;
    localparam logic [7:0] CH_CARET    = 8'd94;
    localparam logic [7:0] CH_SPACE    = 8'd32;   // first printable, also case offset
    localparam logic [7:0] CH_CTRL_OFS = 8'd64;
    localparam logic [7:0] CH_UPPER_A  = 8'd65;
    localparam logic [7:0] CH_UPPER_Z  = 8'd90;

    // input_mode bits
    localparam int IM_CR2NL = 0;
    localparam int IM_IGNCR = 1;
    localparam int IM_NL2CR = 2;
    localparam int IM_LCASE = 3;

    // local_mode bits
    localparam int LM_CANON = 0;
    localparam int LM_SIG   = 1;
    localparam int LM_ECHO  = 2;
    localparam int LM_CARET = 3;

    // register reset values
    localparam logic [3:0] RST_INPUT_MODE = 4'd0;
    localparam logic [3:0] RST_LOCAL_MODE = 4'd13;
    localparam logic [7:0] RST_ERASE_CODE = 8'd127;
    localparam logic [7:0] RST_EOF_CODE   = 8'd4;
    localparam logic [7:0] RST_STOP_CODE  = 8'd19;
    localparam logic [7:0] RST_START_CODE = 8'd17;
    localparam logic [7:0] RST_INTR_CODE  = 8'd3;

    typedef enum logic [2:0] {
        REG_INPUT_MODE = 3'd0,
        REG_LOCAL_MODE = 3'd1,
        REG_ERASE_CODE = 3'd2,
        REG_EOF_CODE   = 3'd3,
        REG_STOP_CODE  = 3'd4,
        REG_START_CODE = 3'd5,
        REG_INTR_CODE  = 3'd6
    } t_reg_idx;

    typedef enum logic {
        REQ_RECV = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef struct packed {
        logic [3:0] input_mode;
        logic [3:0] local_mode;
        logic [7:0] erase_code;
        logic [7:0] eof_code;
        logic [7:0] stop_code;
        logic [7:0] start_code;
        logic [7:0] intr_code;
    } t_cfg;

    typedef struct packed {
        t_req       req_type;
        logic [7:0] raw_byte;
    } t_item;

    // everything one item produces; echo_cnt is 0, 1 or 2
    typedef struct packed {
        logic [1:0]        echo_cnt;
        logic [7:0]        echo0;
        logic [7:0]        echo1;
        logic              read_valid;
        logic [7:0]        read_byte;
        logic              read_is_eof;
        logic              refused;
        logic              intr_raised;
        logic              stopped;
        logic [STAT_W-1:0] lines_ready;
        logic [STAT_W-1:0] fill_level;
    } t_bundle;

endpackage

// ===== rtl/tld_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tld_cfg_regs
// APB register file holding the line discipline modes and control codes.
// ----------------------------------------------------------------------------
module tld_cfg_regs import tld_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_mode <= RST_INPUT_MODE;
            r_cfg.local_mode <= RST_LOCAL_MODE;
            r_cfg.erase_code <= RST_ERASE_CODE;
            r_cfg.eof_code   <= RST_EOF_CODE;
            r_cfg.stop_code  <= RST_STOP_CODE;
            r_cfg.start_code <= RST_START_CODE;
            r_cfg.intr_code  <= RST_INTR_CODE;
        end else if (w_wr) begin
            case (w_idx)
                REG_INPUT_MODE: r_cfg.input_mode <= pwdata[3:0];
                REG_LOCAL_MODE: r_cfg.local_mode <= pwdata[3:0];
                REG_ERASE_CODE: r_cfg.erase_code <= pwdata[7:0];
                REG_EOF_CODE:   r_cfg.eof_code   <= pwdata[7:0];
                REG_STOP_CODE:  r_cfg.stop_code  <= pwdata[7:0];
                REG_START_CODE: r_cfg.start_code <= pwdata[7:0];
                REG_INTR_CODE:  r_cfg.intr_code  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_INPUT_MODE: prdata = {28'd0, r_cfg.input_mode};
            REG_LOCAL_MODE: prdata = {28'd0, r_cfg.local_mode};
            REG_ERASE_CODE: prdata = {24'd0, r_cfg.erase_code};
            REG_EOF_CODE:   prdata = {24'd0, r_cfg.eof_code};
            REG_STOP_CODE:  prdata = {24'd0, r_cfg.stop_code};
            REG_START_CODE: prdata = {24'd0, r_cfg.start_code};
            REG_INTR_CODE:  prdata = {24'd0, r_cfg.intr_code};
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== rtl/tld_core.sv =====
// ----------------------------------------------------------------------------
// tld_core
// Input register, single-pass character processing and the cooked ring.
// ----------------------------------------------------------------------------
module tld_core import tld_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_in_valid,
    input  t_item   i_item,
    output logic    o_in_stall,
    input  logic    i_q_full,
    output logic    o_push,
    output t_bundle o_bundle
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_X  = (PW+1)'(QUEUE_DEPTH);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] w,
                                              input logic [PW-1:0] r);
        logic [PW:0] d;
        if (w >= r) d = {1'b0, w} - {1'b0, r};
        else        d = {1'b0, w} + DEPTH_X - {1'b0, r};
        return d[PW-1:0];
    endfunction

    // input register
    logic              r_in_valid;
    t_item             r_in;
    // ring state
    logic [7:0]        r_mem [QUEUE_DEPTH];
    logic [PW-1:0]     r_wptr, r_rptr;
    logic [STAT_W-1:0] r_lines;
    logic              r_stop;
    // prefetched newest / oldest byte, with write bypass
    logic [7:0]        r_rd_last, r_rd_head, r_byp_data;
    logic              r_byp_last, r_byp_head;

    logic              w_fire, w_accept;
    logic [PW-1:0]     w_fill;
    logic              w_full, w_empty;
    logic [7:0]        w_last_byte, w_head_byte;
    logic [7:0]        w_b;
    logic              w_cr_drop;
    logic              w_store, w_erase, w_pop;
    logic [PW-1:0]     n_wptr, n_rptr;
    logic [STAT_W-1:0] n_lines;
    logic              n_stop;
    logic [PW-1:0]     w_addr_last, w_addr_head;
    logic              w_wr_en;
    t_bundle           w_bnd;

    assign w_fire     = r_in_valid && !i_q_full;
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_fill  = fill_of(r_wptr, r_rptr);
    assign w_full  = (w_fill == PTR_LAST);
    assign w_empty = (w_fill == '0);

    assign w_last_byte = r_byp_last ? r_byp_data : r_rd_last;
    assign w_head_byte = r_byp_head ? r_byp_data : r_rd_head;

    // CR/NL mapping and lowercasing
    always_comb begin
        w_b       = r_in.raw_byte;
        w_cr_drop = 1'b0;
        if (r_in.raw_byte == CH_CR) begin
            if (i_cfg.input_mode[IM_CR2NL])      w_b = CH_NL;
            else if (i_cfg.input_mode[IM_IGNCR]) w_cr_drop = 1'b1;
        end else if (r_in.raw_byte == CH_NL && i_cfg.input_mode[IM_NL2CR]) begin
            w_b = CH_CR;
        end
        if (i_cfg.input_mode[IM_LCASE] && w_b >= CH_UPPER_A && w_b <= CH_UPPER_Z)
            w_b = w_b + CH_SPACE;
    end

    always_comb begin
        w_store = 1'b0;
        w_erase = 1'b0;
        w_pop   = 1'b0;
        n_lines = r_lines;
        n_stop  = r_stop;
        w_bnd   = '0;

        if (r_in.req_type == REQ_POP) begin
            if (w_empty) begin
                w_bnd.refused = 1'b1;
            end else begin
                w_pop             = 1'b1;
                w_bnd.read_valid  = 1'b1;
                w_bnd.read_byte   = w_head_byte;
                w_bnd.read_is_eof = (w_head_byte == i_cfg.eof_code);
                if ((w_head_byte == CH_NL || w_head_byte == i_cfg.eof_code)
                    && r_lines != '0)
                    n_lines = r_lines - 1'b1;
            end
        end else if (w_full) begin
            w_bnd.refused = 1'b1;
        end else if (w_cr_drop) begin
            // ignored CR: nothing queued, nothing echoed
        end else if (i_cfg.local_mode[LM_CANON] && w_b == i_cfg.erase_code) begin
            if (!w_empty && w_last_byte != CH_NL && w_last_byte != i_cfg.eof_code) begin
                w_erase = 1'b1;
                if (i_cfg.local_mode[LM_ECHO]) begin
                    w_bnd.echo0 = CH_DEL;
                    if (w_last_byte < CH_SPACE) begin
                        w_bnd.echo_cnt = 2'd2;
                        w_bnd.echo1    = CH_DEL;
                    end else begin
                        w_bnd.echo_cnt = 2'd1;
                    end
                end
            end
        end else if (i_cfg.local_mode[LM_CANON] && w_b == i_cfg.stop_code) begin
            n_stop = 1'b1;
        end else if (i_cfg.local_mode[LM_CANON] && w_b == i_cfg.start_code) begin
            n_stop = 1'b0;
        end else if (i_cfg.local_mode[LM_SIG] && w_b == i_cfg.intr_code) begin
            w_bnd.intr_raised = 1'b1;
        end else begin
            w_store = 1'b1;
            if ((w_b == CH_NL || w_b == i_cfg.eof_code) && r_lines != LINE_MAX)
                n_lines = r_lines + 1'b1;
            if (i_cfg.local_mode[LM_ECHO]) begin
                if (w_b == CH_NL) begin
                    w_bnd.echo_cnt = 2'd2;
                    w_bnd.echo0    = CH_NL;
                    w_bnd.echo1    = CH_CR;
                end else if (w_b < CH_SPACE) begin
                    if (i_cfg.local_mode[LM_CARET]) begin
                        w_bnd.echo_cnt = 2'd2;
                        w_bnd.echo0    = CH_CARET;
                        w_bnd.echo1    = w_b + CH_CTRL_OFS;
                    end
                end else begin
                    w_bnd.echo_cnt = 2'd1;
                    w_bnd.echo0    = w_b;
                end
            end
        end

        n_wptr = w_store ? ptr_inc(r_wptr) : (w_erase ? ptr_dec(r_wptr) : r_wptr);
        n_rptr = w_pop ? ptr_inc(r_rptr) : r_rptr;

        w_bnd.stopped     = n_stop;
        w_bnd.lines_ready = n_lines;
        w_bnd.fill_level  = STAT_W'(fill_of(n_wptr, n_rptr));
    end

    assign o_push   = w_fire;
    assign o_bundle = w_bnd;

    // prefetch addresses follow the pointers that the next item will see
    assign w_addr_last = ptr_dec(w_fire ? n_wptr : r_wptr);
    assign w_addr_head = w_fire ? n_rptr : r_rptr;
    assign w_wr_en     = w_fire && w_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_lines    <= '0;
            r_stop     <= 1'b0;
            r_byp_last <= 1'b0;
            r_byp_head <= 1'b0;
        end else begin
            if (w_accept)    r_in_valid <= 1'b1;
            else if (w_fire) r_in_valid <= 1'b0;
            if (w_fire) begin
                r_wptr  <= n_wptr;
                r_rptr  <= n_rptr;
                r_lines <= n_lines;
                r_stop  <= n_stop;
            end
            r_byp_last <= w_wr_en && (w_addr_last == r_wptr);
            r_byp_head <= w_wr_en && (w_addr_head == r_wptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_in <= i_item;
        r_byp_data <= w_b;
    end

    // cooked ring: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[r_wptr] <= w_b;
        r_rd_last <= r_mem[w_addr_last];
        r_rd_head <= r_mem[w_addr_head];
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr <= PTR_LAST && r_rptr <= PTR_LAST)
        else $error("ring pointer out of range");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> !w_full)
        else $error("write into full ring");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_pop |=> r_rptr != $past(r_rptr))
        else $error("pop did not advance read pointer");

endmodule

// ===== rtl/tld_out_queue.sv =====
// ----------------------------------------------------------------------------
// tld_out_queue
// Two-entry result queue; splits each entry into one or two transfers.
// ----------------------------------------------------------------------------
module tld_out_queue import tld_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_bundle           i_bundle,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_echo_valid,
    output logic [7:0]        o_echo_byte,
    output logic              o_read_valid,
    output logic [7:0]        o_read_byte,
    output logic              o_read_is_eof,
    output logic              o_refused,
    output logic              o_intr_raised,
    output logic              o_stopped,
    output logic [STAT_W-1:0] o_lines_ready,
    output logic [STAT_W-1:0] o_fill_level,
    output logic              o_last
);

    localparam logic [1:0] Q_ENTRIES = 2'd2;

    t_bundle    r_q [2];
    logic       r_wr, r_rd, r_sub;
    logic [1:0] r_count;
    t_bundle    w_head;
    logic       w_xfer, w_pop;

    assign w_head  = r_q[r_rd];
    assign o_full  = (r_count == Q_ENTRIES);
    assign o_valid = (r_count != '0);

    assign o_echo_valid  = r_sub ? (w_head.echo_cnt == 2'd2) : (w_head.echo_cnt != 2'd0);
    assign o_echo_byte   = r_sub ? w_head.echo1 : w_head.echo0;
    assign o_last        = r_sub || (w_head.echo_cnt != 2'd2);
    assign o_read_valid  = w_head.read_valid;
    assign o_read_byte   = w_head.read_byte;
    assign o_read_is_eof = w_head.read_is_eof;
    assign o_refused     = w_head.refused;
    assign o_intr_raised = w_head.intr_raised;
    assign o_stopped     = w_head.stopped;
    assign o_lines_ready = w_head.lines_ready;
    assign o_fill_level  = w_head.fill_level;

    assign w_xfer = o_valid && !i_stall;
    assign w_pop  = w_xfer && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_sub   <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            if (w_xfer) r_sub <= !o_last;
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_bundle;
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_ENTRIES)
        else $error("result queue overflow");

    a_first_of_two_echoes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_echo_valid)
        else $error("non-final result without echo");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && !o_last |=> o_valid && o_echo_valid && o_last)
        else $error("second echo transfer missing");

endmodule

// ===== rtl/tty_input_line_discipline_top.sv =====
// ----------------------------------------------------------------------------
// tty_input_line_discipline_top
// Receive-side terminal line discipline with cooked queue and echo output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request per transfer:
//   req_type receive (raw byte from the UART) or pop (take one cooked byte).
//   Output channel (o_out_valid / i_out_stall) returns one or two transfers
//   per request; the second is present only when two echo bytes are made
//   (NL+CR, ^X caret form, or double DEL on erase of a control char).
//   o_last marks the final transfer of a request.
//   The request passes through the input register and the processing logic
//   into the result queue, from whose head the first result is offered.
//   Throughput: one request per cycle while each yields a single transfer
//   and i_out_stall is low; a request with two echo bytes takes two output
//   transfers, so the output port sets the rate.
//   The cooked ring is a 1-write/2-read memory; the newest and oldest bytes
//   are prefetched every cycle with write bypass, so no stall is needed.
//   When i_out_stall is high the head result holds; the two-entry result queue
//   fills, one more request waits in the input register, then o_in_stall rises.
//   Reset (sync, active low) empties ring and result queue, clears line count
//   and stop flag, and loads default modes/codes. Ring contents are not
//   cleared; no clearing pass. Config writes only while idle.
// ----------------------------------------------------------------------------
module tty_input_line_discipline_top import tld_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_req_type,
    input  logic [7:0]        i_raw_byte,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_echo_valid,
    output logic [7:0]        o_echo_byte,
    output logic              o_read_valid,
    output logic [7:0]        o_read_byte,
    output logic              o_read_is_eof,
    output logic              o_refused,
    output logic              o_intr_raised,
    output logic              o_stopped,
    output logic [STAT_W-1:0] o_lines_ready,
    output logic [STAT_W-1:0] o_fill_level,
    output logic              o_last
);

    t_cfg    w_cfg;
    t_item   w_item;
    t_bundle w_bundle;
    logic    w_push;
    logic    w_q_full;

    assign w_item.req_type = t_req'(i_req_type);
    assign w_item.raw_byte = i_raw_byte;

    tld_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // all per-request work happens in one pass here
    tld_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .i_item     (w_item),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_bundle   (w_bundle)
    );

    // decouples the receiver's stall from request intake
    tld_out_queue u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_bundle      (w_bundle),
        .o_full        (w_q_full),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_echo_valid  (o_echo_valid),
        .o_echo_byte   (o_echo_byte),
        .o_read_valid  (o_read_valid),
        .o_read_byte   (o_read_byte),
        .o_read_is_eof (o_read_is_eof),
        .o_refused     (o_refused),
        .o_intr_raised (o_intr_raised),
        .o_stopped     (o_stopped),
        .o_lines_ready (o_lines_ready),
        .o_fill_level  (o_fill_level),
        .o_last        (o_last)
    );

endmodule
